FILE: design/swrr_pkg.sv
// Shared types, widths and a helper function of the smooth weighted round-robin selector.
package swrr_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int MASK_W   = 16;
    localparam int IDX_W    = 4;
    localparam int TOTAL_W  = 12;
    localparam int COUNT_W  = 5;
    localparam int CW_W     = 16;
    localparam int WIDE_W   = CW_W + 2;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRV_COUNT  = 2'd2;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   chosen;
        logic [TOTAL_W-1:0] total;
    } t_pick_res;

    typedef logic [CW_W-1:0] t_cw;

    // Clamp a widened signed value into the signed current-weight range.
    function automatic t_cw sat_cw(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(CW_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return {1'b0, {(CW_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(CW_W-1){1'b0}}};
        end else begin
            return v[CW_W-1:0];
        end
    endfunction

endpackage

FILE: design/swrr_cfg.sv
// Configuration register file: packed weights and participating server count.
module swrr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [swrr_pkg::CFG_IDX_W-1:0]      i_idx,
    input  logic [swrr_pkg::WORD_W-1:0]         i_data,
    output logic [2*swrr_pkg::WORD_W-1:0]       o_weights,
    output logic [swrr_pkg::COUNT_W-1:0]        o_count
);

    logic [swrr_pkg::WORD_W-1:0]  r_wlo;
    logic [swrr_pkg::WORD_W-1:0]  r_whi;
    logic [swrr_pkg::COUNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlo   <= '0;
            r_whi   <= '0;
            r_count <= '0;
        end else if (i_wr) begin
            unique case (i_idx)
                swrr_pkg::CFG_WEIGHTS_LO: r_wlo   <= i_data;
                swrr_pkg::CFG_WEIGHTS_HI: r_whi   <= i_data;
                swrr_pkg::CFG_SRV_COUNT:  r_count <= i_data[swrr_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_weights = {r_whi, r_wlo};
    assign o_count   = r_count;

endmodule

FILE: design/swrr_pick.sv
// Single-pass selection: weight add, maximum tree, winner subtract.
module swrr_pick #(
    parameter int MAX_SERVERS = swrr_pkg::MAX_SERVERS_DEF,
    parameter int WEIGHT_BITS = swrr_pkg::WEIGHT_BITS_DEF
) (
    input  logic [swrr_pkg::MASK_W-1:0]              i_mask,
    input  logic [2*swrr_pkg::WORD_W-1:0]            i_weights,
    input  logic [swrr_pkg::COUNT_W-1:0]             i_count,
    input  logic [MAX_SERVERS-1:0][swrr_pkg::CW_W-1:0] i_cw,
    output logic [MAX_SERVERS-1:0][swrr_pkg::CW_W-1:0] o_cw_next,
    output swrr_pkg::t_pick_res                      o_res
);

    localparam int LEVELS = $clog2(MAX_SERVERS);
    localparam int NPAD   = 1 << LEVELS;
    localparam logic [swrr_pkg::COUNT_W-1:0] MAX_CNT = swrr_pkg::COUNT_W'(MAX_SERVERS);

    typedef struct packed {
        logic                              vld;
        logic signed [swrr_pkg::CW_W-1:0]  val;
        logic [swrr_pkg::IDX_W-1:0]        idx;
    } t_node;

    logic [swrr_pkg::COUNT_W-1:0]                    eff_cnt;
    logic [MAX_SERVERS-1:0]                          elig;
    logic [MAX_SERVERS-1:0][swrr_pkg::BYTE_W-1:0]    wt;
    logic [MAX_SERVERS-1:0][swrr_pkg::CW_W-1:0]      added;
    logic [swrr_pkg::TOTAL_W-1:0]                    total;
    t_node                                           nodes [1:2*NPAD-1];
    logic                                            found;
    logic [swrr_pkg::CW_W-1:0]                       win_sub;

    assign eff_cnt = (i_count > MAX_CNT) ? MAX_CNT : i_count;

    // Per-server add and leaf setup.
    always_comb begin
        total = '0;
        for (int i = 0; i < MAX_SERVERS; i++) begin
            elig[i]  = (swrr_pkg::COUNT_W'(i) < eff_cnt) && i_mask[i];
            wt[i]    = swrr_pkg::BYTE_W'(i_weights[swrr_pkg::BYTE_W*i +: WEIGHT_BITS]);
            added[i] = swrr_pkg::sat_cw(
                swrr_pkg::WIDE_W'(signed'(i_cw[i])) +
                signed'(swrr_pkg::WIDE_W'(wt[i])));
            if (elig[i]) begin
                total = total + swrr_pkg::TOTAL_W'(wt[i]);
            end
        end
    end

    // Maximum tree; the left child holds lower indexes, so ties keep the left.
    always_comb begin
        for (int k = 0; k < NPAD; k++) begin
            if (k < MAX_SERVERS) begin
                nodes[NPAD+k].vld = elig[k];
                nodes[NPAD+k].val = signed'(added[k]);
            end else begin
                nodes[NPAD+k].vld = 1'b0;
                nodes[NPAD+k].val = '0;
            end
            nodes[NPAD+k].idx = swrr_pkg::IDX_W'(k);
        end
        for (int k = NPAD - 1; k >= 1; k--) begin
            if (nodes[2*k].vld &&
                (!nodes[2*k+1].vld || nodes[2*k].val >= nodes[2*k+1].val)) begin
                nodes[k] = nodes[2*k];
            end else begin
                nodes[k] = nodes[2*k+1];
            end
        end
    end

    assign found   = nodes[1].vld && (total != '0);
    assign win_sub = swrr_pkg::sat_cw(
        swrr_pkg::WIDE_W'(nodes[1].val) -
        signed'(swrr_pkg::WIDE_W'(total)));

    always_comb begin
        for (int i = 0; i < MAX_SERVERS; i++) begin
            if (!found) begin
                o_cw_next[i] = i_cw[i];
            end else if (swrr_pkg::IDX_W'(i) == nodes[1].idx) begin
                o_cw_next[i] = win_sub;
            end else if (elig[i]) begin
                o_cw_next[i] = added[i];
            end else begin
                o_cw_next[i] = i_cw[i];
            end
        end
    end

    assign o_res.found  = found;
    assign o_res.chosen = found ? nodes[1].idx : '0;
    assign o_res.total  = total;

endmodule

FILE: design/smooth_weighted_round_robin.sv
// Top level of the smooth weighted round-robin selector with stream ports.
//
//  Channel      Direction  Word contents (low bit first)
//  s_axis       in         tdata[15:0] healthy_mask
//  m_axis       out        tdata[0] found, [4:1] chosen_server, [16:5] healthy_total
//  cfg          in         index 0 weights 0-7, 1 weights 8-15, 2 server count
//
// One word is accepted per cycle while the output is not stalled. A word goes
// first into the input register; its result enters the output register as the
// word leaves the input register, and the result word is then offered.
// The current weights update in the same cycle the selection is made, which
// lets the next word see them at once; the add, maximum tree and subtract sit
// between the input register and the result register.
// Reset clears the weights, the count, all current weights and both valid flags.
// A stalled output holds its word while the input register still takes one more.
module smooth_weighted_round_robin #(
    parameter int MAX_SERVERS = swrr_pkg::MAX_SERVERS_DEF,
    parameter int WEIGHT_BITS = swrr_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream: tdata[15:0] = healthy_mask.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [swrr_pkg::IN_W-1:0]         i_s_axis_tdata,
    // Output stream: tdata[0] = found, [4:1] = chosen_server,
    // [16:5] = healthy_total, [23:17] = zero.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [swrr_pkg::OUT_W-1:0]        o_m_axis_tdata,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swrr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swrr_pkg::WORD_W-1:0]       i_cfg_data
);

    logic [2*swrr_pkg::WORD_W-1:0]               weights;
    logic [swrr_pkg::COUNT_W-1:0]                count;

    logic                                        r_in_vld;
    logic [swrr_pkg::MASK_W-1:0]                 r_mask;
    logic                                        r_out_vld;
    swrr_pkg::t_pick_res                         r_out;
    logic [MAX_SERVERS-1:0][swrr_pkg::CW_W-1:0]  r_cw;

    logic [MAX_SERVERS-1:0][swrr_pkg::CW_W-1:0]  n_cw;
    swrr_pkg::t_pick_res                         n_res;

    logic                                        fire;
    logic                                        in_take;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    swrr_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_cfg_valid),
        .i_idx     (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_weights (weights),
        .o_count   (count)
    );

    swrr_pick #(
        .MAX_SERVERS (MAX_SERVERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_pick (
        .i_mask    (r_mask),
        .i_weights (weights),
        .i_count   (count),
        .i_cw      (r_cw),
        .o_cw_next (n_cw),
        .o_res     (n_res)
    );

    // A selection happens when a word waits in the input register and the
    // output register is empty or being drained this cycle.
    assign fire            = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cw      <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
                r_cw      <= n_cw;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mask <= i_s_axis_tdata[swrr_pkg::MASK_W-1:0];
        end
        if (fire) begin
            r_out <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {
        {(swrr_pkg::OUT_W - swrr_pkg::TOTAL_W - swrr_pkg::IDX_W - 1){1'b0}},
        r_out.total, r_out.chosen, r_out.found};

    // A result with nothing found names server zero.
    a_notfound_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.found) |-> (r_out.chosen == '0))
        else $error("chosen server nonzero without a winner");

    // A winner always comes with a nonzero healthy total.
    a_found_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.found) |-> (r_out.total != '0))
        else $error("winner reported with zero total");

    // Current weights stay put when a selection finds nothing.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !n_res.found) |=> $stable(r_cw))
        else $error("current weights changed without a winner");

    // Every selection lands in the output register.
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("selection lost");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the smooth weighted round-robin selector.
module tb;

    // Generous cycle budget, well above the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 12;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_valid = 1'b0;
    logic [swrr_pkg::IN_W-1:0]        s_data = '0;
    logic                             m_ready = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [swrr_pkg::CFG_IDX_W-1:0]   cfg_index = swrr_pkg::CFG_WEIGHTS_LO;
    logic [swrr_pkg::WORD_W-1:0]      cfg_data = '0;
    logic                             o_s_axis_tready;
    logic                             o_m_axis_tvalid;
    logic [swrr_pkg::OUT_W-1:0]       o_m_axis_tdata;
    logic                             o_cfg_ready;

    // Shadow copy of the configuration and the per-server current weights.
    logic [swrr_pkg::WORD_W-1:0]      wt_lo = '0;
    logic [swrr_pkg::WORD_W-1:0]      wt_hi = '0;
    logic [swrr_pkg::COUNT_W-1:0]     srv_cnt = '0;
    logic signed [swrr_pkg::CW_W-1:0] cur_wt [swrr_pkg::MAX_SERVERS_DEF];

    // Picks predicted for accepted request words, oldest first.
    swrr_pkg::t_pick_res              pending_picks [$];

    int  err_count   = 0;
    int  n_requests  = 0;
    int  n_picks     = 0;
    int  n_found     = 0;
    int  n_settings  = 0;
    int  cycles      = 0;
    int  hold_req    = 0;
    bit  calm        = 1'b0;
    logic rx_hold    = 1'b0;

    smooth_weighted_round_robin i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int clamp_cw(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int weight_of(input int idx);
        if (idx < 8) return int'(wt_lo[8*idx +: 8]);
        return int'(wt_hi[8*(idx-8) +: 8]);
    endfunction

    // Computes the pick for one healthy mask and advances the current weights.
    // With 16 servers and 8-bit weights the current weights stay well inside
    // 16 bits, so the clamp only guards the arithmetic.
    function automatic swrr_pkg::t_pick_res pick_next_server(
        input logic [swrr_pkg::MASK_W-1:0] mask);
        int                  nxt [swrr_pkg::MAX_SERVERS_DEF];
        int                  lim;
        int                  total;
        int                  best;
        int                  best_val;
        bit                  any;
        swrr_pkg::t_pick_res r;
        lim      = (srv_cnt > swrr_pkg::MAX_SERVERS_DEF) ? swrr_pkg::MAX_SERVERS_DEF
                                                         : int'(srv_cnt);
        total    = 0;
        best     = 0;
        best_val = 0;
        any      = 1'b0;
        for (int i = 0; i < swrr_pkg::MAX_SERVERS_DEF; i++) begin
            nxt[i] = int'(cur_wt[i]);
            if (i < lim && mask[i]) begin
                total += weight_of(i);
                nxt[i] = clamp_cw(nxt[i] + weight_of(i));
                // The first healthy server seeds the maximum, so an all-negative
                // set of current weights still yields its true maximum.
                if (!any || nxt[i] > best_val) begin
                    any      = 1'b1;
                    best     = i;
                    best_val = nxt[i];
                end
            end
        end
        r.total = total[swrr_pkg::TOTAL_W-1:0];
        if (any && total != 0) begin
            nxt[best] = clamp_cw(nxt[best] - total);
            for (int i = 0; i < swrr_pkg::MAX_SERVERS_DEF; i++)
                cur_wt[i] = nxt[i][swrr_pkg::CW_W-1:0];
            r.found  = 1'b1;
            r.chosen = best[swrr_pkg::IDX_W-1:0];
        end else begin
            r.found  = 1'b0;
            r.chosen = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("tb: mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Result side: checks every accepted word against the oldest pick and
    // drops tready at random, or for a long stretch while a hold is active.
    always @(posedge i_clk) begin
        swrr_pkg::t_pick_res want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                n_picks++;
                if (pending_picks.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", o_m_axis_tdata));
                end else begin
                    want = pending_picks.pop_front();
                    if (want.found) n_found++;
                    if (o_m_axis_tdata[0] !== want.found)
                        report_mismatch($sformatf("found %b, want %b",
                                                  o_m_axis_tdata[0], want.found));
                    if (o_m_axis_tdata[4:1] !== want.chosen)
                        report_mismatch($sformatf("chosen_server %0d, want %0d",
                                                  o_m_axis_tdata[4:1], want.chosen));
                    if (o_m_axis_tdata[16:5] !== want.total)
                        report_mismatch($sformatf("healthy_total %0d, want %0d",
                                                  o_m_axis_tdata[16:5], want.total));
                    if (o_m_axis_tdata[swrr_pkg::OUT_W-1:17] !== '0)
                        report_mismatch($sformatf("padding bits %h not zero",
                                                  o_m_axis_tdata[swrr_pkg::OUT_W-1:17]));
                end
            end
            if (rx_hold)
                m_ready <= 1'b0;
            else if (calm)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering words.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                rx_hold <= 1'b1;
                repeat (n) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        end
    end

    // Offers one request word, with a random gap first, and predicts its pick
    // once the word is taken. tvalid stays high afterwards so back-to-back
    // words need no second assignment in one time step.
    task automatic send_mask(input logic [swrr_pkg::MASK_W-1:0] mask);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= mask;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_picks.push_back(pick_next_server(mask));
        n_requests++;
    endtask

    // Stops offering words and waits until every pick has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swrr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swrr_pkg::WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            swrr_pkg::CFG_WEIGHTS_LO: wt_lo = val;
            swrr_pkg::CFG_WEIGHTS_HI: wt_hi = val;
            swrr_pkg::CFG_SRV_COUNT:  srv_cnt = val[swrr_pkg::COUNT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_group(input logic [swrr_pkg::WORD_W-1:0] lo,
                             input logic [swrr_pkg::WORD_W-1:0] hi,
                             input logic [swrr_pkg::COUNT_W-1:0] cnt);
        write_reg(swrr_pkg::CFG_WEIGHTS_LO, lo);
        write_reg(swrr_pkg::CFG_WEIGHTS_HI, hi);
        write_reg(swrr_pkg::CFG_SRV_COUNT, swrr_pkg::WORD_W'(cnt));
        n_settings++;
    endtask

    function automatic logic [swrr_pkg::MASK_W-1:0] rand_mask();
        int k;
        k = $urandom_range(0, swrr_pkg::MASK_W-1);
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return swrr_pkg::MASK_W'(1) << k;
            2:       return '0;
            3:       return ~(swrr_pkg::MASK_W'(1) << k);
            default: return swrr_pkg::MASK_W'($urandom);
        endcase
    endfunction

    function automatic logic [swrr_pkg::WORD_W-1:0] rand_weights();
        logic [swrr_pkg::WORD_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = '1;
            1: w = '0;
            2: for (int b = 0; b < 8; b++) if ($urandom_range(0, 1)) w[8*b +: 8] = '0;
            3: for (int b = 0; b < 8; b++) w[8*b +: 8] = 8'($urandom_range(0, 3));
            default: ;
        endcase
        return w;
    endfunction

    // With count zero nothing can be picked, whatever the mask.
    task automatic test_after_reset();
        send_mask('1);
        send_mask('0);
        drain();
    endtask

    // Equal weights: ties go to the lowest index, and after two picks from the full
    // group the two lowest servers are both negative, so the pick must still be the
    // larger of two negative current weights.
    task automatic test_full_weights();
        set_group('1, '1, 5'd16);
        send_mask('1);
        send_mask('1);
        send_mask(16'h0003);
        send_mask('0);
        send_mask(16'h8000);
        send_mask(16'h0001);
        send_mask(16'hAAAA);
        send_mask(16'h5555);
        drain();
    endtask

    // A count above the number of servers acts as the full group.
    task automatic test_count_limit();
        set_group(64'h0102_0408_1020_4080, 64'hFF7F_3F1F_0F07_0301, 5'd31);
        send_mask('1);
        send_mask(16'h8000);
        drain();
        write_reg(swrr_pkg::CFG_SRV_COUNT, swrr_pkg::WORD_W'(17));
        send_mask(16'hC001);
        send_mask('1);
        drain();
    endtask

    // Mask bits at or above the count are ignored.
    task automatic test_mask_beyond_count();
        set_group(64'h0807_0605_0403_0201, 64'h1010_1010_1010_1010, 5'd3);
        send_mask(16'hFFF8);
        send_mask('1);
        send_mask(16'h0004);
        drain();
        write_reg(swrr_pkg::CFG_SRV_COUNT, swrr_pkg::WORD_W'(1));
        send_mask(16'h0001);
        send_mask(16'hFFFE);
        drain();
    endtask

    // Healthy servers whose weights add to zero give no pick and no update.
    task automatic test_zero_weights();
        set_group('0, '0, 5'd16);
        send_mask('1);
        drain();
        set_group(64'hFFFF_FFFF_FFFF_FF00, '1, 5'd16);
        send_mask(16'h0001);
        send_mask(16'h0003);
        drain();
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        logic [swrr_pkg::COUNT_W-1:0] cnt;
        for (int p = 0; p < phases; p++) begin
            if ($urandom_range(0, 4) == 0)
                cnt = swrr_pkg::COUNT_W'($urandom_range(17, 31));
            else
                cnt = swrr_pkg::COUNT_W'($urandom_range(1, 16));
            set_group(rand_weights(), rand_weights(), cnt);
            for (int i = 0; i < per_phase; i++) send_mask(rand_mask());
            drain();
        end
    endtask

    // Neither side idles for a whole phase.
    task automatic test_calm_stretch();
        calm = 1'b1;
        test_random_settings(1, 60);
        calm = 1'b0;
    endtask

    // The receiver stalls for a long stretch while words keep coming, so the
    // block fills and must hold back its input without losing a pick.
    task automatic test_backpressure();
        set_group(rand_weights(), rand_weights(), 5'd16);
        calm = 1'b1;
        hold_req <= HOLD_CYCLES;
        for (int i = 0; i < 40; i++) send_mask(rand_mask());
        drain();
        calm = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < swrr_pkg::MAX_SERVERS_DEF; i++) cur_wt[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_full_weights();
        test_count_limit();
        test_mask_beyond_count();
        test_zero_weights();
        test_random_settings(10, 100);
        test_calm_stretch();
        test_backpressure();

        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb: %0d requests, %0d picks checked (%0d found) over %0d group settings",
                 n_requests, n_picks, n_found, n_settings);
        $display("tb: ties, negative maxima, count limits, zero totals and a long stall");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", err_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
